// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for RTL files that check their own behavior.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/aes128_pkg.sv -----
// Package for the AES-128 encryption pipeline: S-box, round constants, stage type
// and the round transforms. No dependencies.
`default_nettype none

package aes128_pkg;

	localparam int NumRounds = 10;
	localparam int BlockBits = 128;

	localparam logic KeyHighIdx = 1'b0;
	localparam logic KeyLowIdx = 1'b1;

	typedef logic [BlockBits-1:0] block_t;

	typedef struct packed {
		block_t state;
		block_t rkey;
	} stage_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte n of the block sits at bits [127-8n -: 8].
	function automatic logic [7:0] get_byte(input block_t b, input int n);
		return b[BlockBits-1-8*n -: 8];
	endfunction

	function automatic block_t sub_shift(input block_t b);
		block_t t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[BlockBits-1-8*(r+4*c) -: 8] = SBOX[get_byte(b, r + 4*((c + r) % 4))];
			end
		end
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t b);
		block_t t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(b, 4*c);
			a1 = get_byte(b, 4*c + 1);
			a2 = get_byte(b, 4*c + 2);
			a3 = get_byte(b, 4*c + 3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[BlockBits-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic block_t next_key(input block_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, tw, n0, n1, n2, n3;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		n0 = w0 ^ tw;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/aes128_round_cell.sv -----
// One round cell of the AES-128 pipeline: expands its round key from the previous one
// and applies one cipher round, holding the result in its stage register. Uses aes128_pkg.
`default_nettype none

module aes128_round_cell
	import aes128_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       up_valid,
	input  wire stage_t     up_data,
	input  wire logic [7:0] rcon,
	input  wire logic       last_round,
	input  wire logic       dn_take,
	output logic            take,
	output logic            valid_s1,
	output stage_t          data_s1
);

	block_t rkey;
	block_t shifted;
	block_t mixed;
	stage_t next_data;

	always_comb begin
		rkey = next_key(up_data.rkey, rcon);
		shifted = sub_shift(up_data.state);
		mixed = last_round ? shifted : mix_columns(shifted);
		next_data.state = mixed ^ rkey;
		next_data.rkey = rkey;
	end

	assign take = !valid_s1 || dn_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && up_valid) begin
			data_s1 <= next_data;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/aes128_block_encrypt.sv -----
// AES-128 block encryption: a whitening stage followed by a chain of ten round cells.
// Words pass whitening, then the round cells; one word per cycle unless stalled.
// Each cell holds a stage register, so a stalled output only stops cells that are full.
// Reset clears the valid bits and both key registers to zero.
// Depends on aes128_pkg, aes128_round_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module aes128_block_encrypt
	import aes128_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] plain_high,
	input  wire logic [63:0] plain_low,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;

	logic   stage_valid [NumRounds+1];
	stage_t stage_data  [NumRounds+1];
	logic   stage_take  [NumRounds+2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				KeyHighIdx: key_high_q <= cfg_data;
				KeyLowIdx: key_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stage_take[0] = !stage_valid[0] || stage_take[1];
	assign stage_take[NumRounds+1] = !out_stall;
	assign in_stall = !stage_take[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid[0] <= 1'b0;
		end else if (stage_take[0]) begin
			stage_valid[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_take[0] && in_valid) begin
			stage_data[0].state <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			stage_data[0].rkey <= {key_high_q, key_low_q};
		end
	end

	for (genvar i = 1; i <= NumRounds; i++) begin : g_round
		aes128_round_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (stage_valid[i-1]),
			.up_data    (stage_data[i-1]),
			.rcon       (RCON[i-1]),
			.last_round (i == NumRounds),
			.dn_take    (stage_take[i+1]),
			.take       (stage_take[i]),
			.valid_s1   (stage_valid[i]),
			.data_s1    (stage_data[i])
		);
	end

	assign out_valid = stage_valid[NumRounds];
	assign cipher_high = stage_data[NumRounds].state[127:64];
	assign cipher_low = stage_data[NumRounds].state[63:0];

	`ASSERT_NEXT(a_accept_fills_first, clk, arst_n, in_valid && !in_stall, stage_valid[0],
		"Accepted word did not reach the whitening stage.")
	`ASSERT_SAME(a_empty_never_stalls, clk, arst_n, !stage_valid[0], !in_stall,
		"Input stalled while the whitening stage was empty.")
	`ASSERT_NEXT(a_stalled_result_held, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(cipher_high) && $stable(cipher_low),
		"Result word changed while stalled.")
	`ASSERT_SAME(a_cfg_always_ready, clk, arst_n, cfg_valid, cfg_ready,
		"Configuration write was not taken.")

endmodule

`default_nettype wire
